// ----- rtl/core/teq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package teq_pkg;
  localparam int unsigned Slots = 16;
  localparam int unsigned SlotW = 4;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SERVICE = 2'd1,
    OP_REG     = 2'd2,
    OP_UNREG   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  event_id;
    logic [31:0] timeout;
    logic        periodic;
  } in_req_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] fired_id;
    logic       status;
    logic       last;
  } out_req_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;        // capture input request
    logic       tick;
    logic       unreg;
    logic       arm_in;      // arm slot from input request
    logic       scan_clr;    // start new minimum search
    logic       scan_step;   // compare one slot
    logic       fire;        // fire the found slot
    logic       emit;        // load output register
    logic       emit_kind;
    logic       emit_status;
    logic       emit_last;
    logic       emit_found;  // id from search result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0]       operation;
    logic             id_ok;
    logic             tmo_zero;
    logic             periodic;
    logic             scan_done;
    logic             found;
    logic [SlotW-1:0] best_id;   // slot picked by the last search
    logic [4:0]       fire_cnt;
    logic             out_busy;
  } sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/teq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module teq_datapath import teq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_req_t  in_i,
  input  wire cmd_t     cmd_i,
  input  wire logic     out_stall_i,
  output sts_t          sts_o,
  output logic          out_valid_o,
  output out_req_t      out_o
);
  logic [63:0] now_q;
  logic [31:0] arm_cnt_q;
  logic [Slots-1:0] armed_q, per_q;
  logic [31:0] intv_q [Slots];
  logic [63:0] dl_q   [Slots];
  logic [31:0] ord_q  [Slots];
  in_req_t     req_q;
  logic [SlotW:0] scan_q;
  logic        found_q;
  logic [SlotW-1:0] best_q;
  logic [63:0] best_dl_q;
  logic [31:0] best_age_q;
  logic [4:0]  fire_cnt_q;
  logic        out_valid_q;
  out_req_t    out_q;

  logic [SlotW-1:0] cur;
  logic [31:0] cur_age;
  logic        better;
  assign cur     = scan_q[SlotW-1:0];
  assign cur_age = arm_cnt_q - ord_q[cur];
  assign better  = armed_q[cur] && (dl_q[cur] <= now_q) &&
                   (!found_q || dl_q[cur] < best_dl_q ||
                    (dl_q[cur] == best_dl_q && cur_age < best_age_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
      arm_cnt_q <= '0;
      armed_q <= '0;
      per_q <= '0;
      scan_q <= '0;
      found_q <= 1'b0;
      fire_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cmd_i.tick) now_q <= now_q + 64'd1;
      if (cmd_i.unreg) armed_q[req_q.event_id] <= 1'b0;
      if (cmd_i.arm_in) begin
        arm_cnt_q <= arm_cnt_q + 32'd1;
        armed_q[req_q.event_id] <= 1'b1;
        per_q[req_q.event_id] <= req_q.periodic;
      end
      if (cmd_i.load) fire_cnt_q <= '0;
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_q <= scan_q + 1'b1;
        if (better) found_q <= 1'b1;
      end
      if (cmd_i.fire) begin
        fire_cnt_q <= fire_cnt_q + 5'd1;
        if (per_q[best_q]) arm_cnt_q <= arm_cnt_q + 32'd1;
        else armed_q[best_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_i;
    if (cmd_i.arm_in) begin
      intv_q[req_q.event_id] <= req_q.timeout;
      dl_q[req_q.event_id]   <= now_q + {32'd0, req_q.timeout};
      ord_q[req_q.event_id]  <= arm_cnt_q + 32'd1;
    end
    if (cmd_i.scan_step && better) begin
      best_q <= cur;
      best_dl_q <= dl_q[cur];
      best_age_q <= cur_age;
    end
    if (cmd_i.fire && per_q[best_q]) begin
      dl_q[best_q]  <= now_q + {32'd0, intv_q[best_q]};
      ord_q[best_q] <= arm_cnt_q + 32'd1;
    end
    if (cmd_i.emit) begin
      out_q.kind     <= cmd_i.emit_kind;
      out_q.fired_id <= cmd_i.emit_found ? best_q : req_q.event_id;
      out_q.status   <= cmd_i.emit_status;
      out_q.last     <= cmd_i.emit_last;
    end
  end

  assign sts_o.operation = req_q.operation;
  assign sts_o.id_ok     = ({1'b0, req_q.event_id} < 5'(Slots));
  assign sts_o.tmo_zero  = (req_q.timeout == '0);
  assign sts_o.periodic  = req_q.periodic;
  assign sts_o.scan_done = (scan_q == (SlotW+1)'(Slots));
  assign sts_o.found     = found_q;
  assign sts_o.best_id   = best_q;
  assign sts_o.fire_cnt  = fire_cnt_q;
  assign sts_o.out_busy  = out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
endmodule
`default_nettype wire

// ----- rtl/core/teq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module teq_ctrl import teq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FIRE = 3'd3;
  localparam logic [2:0] S_ZST  = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        case (sts_i.operation)
          OP_TICK: begin
            cmd_o.tick = 1'b1;
            state_d = S_IDLE;
          end
          OP_SERVICE: begin
            cmd_o.scan_clr = 1'b1;
            state_d = S_SCAN;
          end
          OP_REG: begin
            if (!sts_i.id_ok) state_d = S_IDLE;
            else if (!sts_i.out_busy) begin
              cmd_o.emit = 1'b1;
              if (sts_i.tmo_zero) begin
                cmd_o.emit_kind = 1'b1;
                state_d = S_ZST;
              end else begin
                cmd_o.arm_in = 1'b1;
                cmd_o.emit_last = 1'b1;
                state_d = S_IDLE;
              end
            end
          end
          default: begin
            cmd_o.unreg = sts_i.id_ok;
            state_d = S_IDLE;
          end
        endcase
      end
      S_ZST: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_status = sts_i.periodic;
          cmd_o.emit_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        // final scan: stay until the last fire has left the buffer
        if (!sts_i.scan_done) cmd_o.scan_step = 1'b1;
        else if (sts_i.found) state_d = S_FIRE;
        else if (!sts_i.out_busy) state_d = S_IDLE;
      end
      S_FIRE: begin
        // hold fire until output slot frees; last known only after rescan
        if (!sts_i.out_busy) begin
          state_d = S_SCAN;
          cmd_o.fire = 1'b1;
          cmd_o.scan_clr = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/core/teq_fire_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Holds a fired id until the rescan tells whether it was the last one.
module teq_fire_buf import teq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire logic [3:0] id_i,
  input  wire logic     flush_i,
  input  wire logic     more_i,
  input  wire logic     out_stall_i,
  output logic          busy_o,
  output logic          out_valid_o,
  output out_req_t      out_o
);
  logic       pend_q, valid_q;
  logic [3:0] id_q;
  out_req_t   out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (valid_q && !out_stall_i) valid_q <= 1'b0;
      if (flush_i && pend_q) begin
        pend_q <= 1'b0;
        valid_q <= 1'b1;
      end
      if (push_i) pend_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) id_q <= id_i;
    if (flush_i && pend_q) begin
      out_q.kind <= 1'b1;
      out_q.fired_id <= id_q;
      out_q.status <= 1'b0;
      out_q.last <= !more_i;
    end
  end

  assign busy_o      = valid_q || pend_q;
  assign out_valid_o = valid_q;
  assign out_o       = out_q;
endmodule
`default_nettype wire

// ----- rtl/core/timer_event_queue_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Results: a register request gives one result, two with a zero timeout;
//   tick and unregister requests give none.
// Service: a 16-step slot scan plus a done check per search, one search per
//   fired event plus a final one; the minimum search is sequential.
// One request at a time; stall is high until the request is finished.
// Reset (async, active low) clears the clock, arm counter and all armed bits.
module timer_event_queue_top import teq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_req_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_req_t      out_req_o
);
  cmd_t     cmd, cmd_dp;
  sts_t     sts_dp, sts;
  logic     dp_valid, fb_valid, fb_busy;
  out_req_t dp_out, fb_out;
  logic     last_fire_q, in_service_q;

  teq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sts_i(sts), .cmd_o(cmd)
  );

  // Service fires go through the buffer; the datapath output carries register results.
  always_comb begin
    cmd_dp = cmd;
    sts = sts_dp;
    sts.out_busy = sts_dp.out_busy || fb_busy;
    // fire cap: the sixteenth fire ends the request
    if (sts_dp.fire_cnt == 5'd16 && in_service_q) sts.found = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_service_q <= 1'b0;
      last_fire_q <= 1'b0;
    end else begin
      if (cmd.load) in_service_q <= (in_req_i.operation == OP_SERVICE);
      last_fire_q <= cmd.fire;
    end
  end

  teq_datapath u_dp (
    .clk_i, .rst_ni, .in_i(in_req_i), .cmd_i(cmd_dp), .out_stall_i,
    .sts_o(sts_dp), .out_valid_o(dp_valid), .out_o(dp_out)
  );

  // After each fire, the next scan end decides "last" for the buffered id.
  logic scan_end;
  assign scan_end = in_service_q && sts_dp.scan_done && !last_fire_q &&
                    !cmd.scan_clr;
  teq_fire_buf u_fb (
    .clk_i, .rst_ni, .push_i(cmd.fire), .id_i(sts_dp.best_id),
    .flush_i(scan_end && !fb_valid), .more_i(sts.found),
    .out_stall_i, .busy_o(fb_busy), .out_valid_o(fb_valid), .out_o(fb_out)
  );

  assign out_valid_o = dp_valid || fb_valid;
  assign out_req_o   = fb_valid ? fb_out : dp_out;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(dp_valid && fb_valid))
    else $error("two result sources at once");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fire |-> sts_dp.found)
    else $error("fire without a due slot");
endmodule
`default_nettype wire

// ----- tb/tb_timer_event_queue_top.sv -----
`timescale 1ns / 1ps
module tb_timer_event_queue_top;
  import teq_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_req_t out_req_o;

  timer_event_queue_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_req_o(out_req_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the scheduler state
  logic [63:0] clock_ticks;
  logic        armed_q   [Slots];
  logic        repeat_q  [Slots];
  logic [31:0] interval_q[Slots];
  logic [63:0] deadline_q[Slots];
  logic [31:0] order_q   [Slots];
  logic [31:0] arm_seq;

  out_req_t pending_fires[$];  // results still owed by the block
  int       errors = 0;
  bit       stim_done = 1'b0;

  function automatic out_req_t mk_res(logic kind, logic [3:0] id, logic st);
    out_req_t r;
    r.kind = kind; r.fired_id = id; r.status = st; r.last = 1'b0;
    return r;
  endfunction

  function automatic void arm(int s, logic [31:0] ivl, logic per);
    arm_seq++;
    armed_q[s] = 1'b1; repeat_q[s] = per; interval_q[s] = ivl;
    deadline_q[s] = clock_ticks + 64'(ivl);
    order_q[s] = arm_seq;
  endfunction

  // Earliest due slot; ties go to the most recently armed one.
  function automatic int earliest_due();
    int best;
    logic [31:0] best_age, age;
    best = -1; best_age = '0;
    for (int s = 0; s < Slots; s++) begin
      if (!armed_q[s] || deadline_q[s] > clock_ticks) continue;
      age = arm_seq - order_q[s];
      if (best < 0 || deadline_q[s] < deadline_q[best] ||
          (deadline_q[s] == deadline_q[best] && age < best_age)) begin
        best = s; best_age = age;
      end
    end
    return best;
  endfunction

  // Advance the shadow state by one request and queue its results.
  task automatic schedule_request(in_req_t r);
    out_req_t res[$];
    int s;
    case (op_e'(r.operation))
      OP_TICK: clock_ticks++;
      OP_SERVICE: begin
        while (res.size() < 16) begin
          s = earliest_due();
          if (s < 0) break;
          res.push_back(mk_res(1'b1, 4'(s), 1'b0));
          if (repeat_q[s]) arm(s, interval_q[s], 1'b1);
          else armed_q[s] = 1'b0;
        end
      end
      OP_REG: begin
        if (r.timeout == '0) begin
          res.push_back(mk_res(1'b1, r.event_id, 1'b0));
          res.push_back(mk_res(1'b0, r.event_id, r.periodic));
        end else begin
          arm(r.event_id, r.timeout, r.periodic);
          res.push_back(mk_res(1'b0, r.event_id, 1'b0));
        end
      end
      OP_UNREG: armed_q[r.event_id] = 1'b0;
      default: ;
    endcase
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) pending_fires.push_back(res[i]);
  endtask

  // Directed table: op, id, timeout, periodic. Where want_n >= 0 the number
  // of results is fixed by inspection; everything is still predictor-checked.
  typedef struct {
    op_e         op;
    logic [3:0]  id;
    logic [31:0] tmo;
    logic        per;
    int          want_n;
  } row_t;

  row_t dir_rows[] = '{
    '{OP_SERVICE, 4'd0,  32'd0,          1'b0, 0},  // nothing armed after reset
    '{OP_REG,     4'd0,  32'd0,          1'b0, 2},  // zero timeout fires at once
    '{OP_REG,     4'd15, 32'd0,          1'b1, 2},  // periodic zero timeout: error
    '{OP_REG,     4'd3,  32'd1,          1'b0, 1},
    '{OP_REG,     4'd4,  32'd1,          1'b0, 1},  // equal deadline, newer
    '{OP_REG,     4'd5,  32'd2,          1'b1, 1},
    '{OP_REG,     4'd15, 32'hFFFF_FFFF,  1'b1, 1},  // max timeout
    '{OP_SERVICE, 4'd0,  32'd0,          1'b0, 0},  // nothing due yet
    '{OP_TICK,    4'd0,  32'd0,          1'b0, 0},
    '{OP_SERVICE, 4'd0,  32'd0,          1'b0, 2},  // 4 before 3
    '{OP_TICK,    4'd0,  32'd0,          1'b0, 0},
    '{OP_SERVICE, 4'd0,  32'd0,          1'b0, 1},  // periodic 5
    '{OP_REG,     4'd7,  32'd5,          1'b0, 1},
    '{OP_REG,     4'd7,  32'd1,          1'b0, 1},  // re-arm overwrites
    '{OP_UNREG,   4'd5,  32'd0,          1'b0, 0},
    '{OP_UNREG,   4'd9,  32'd0,          1'b0, 0},  // idle slot
    '{OP_TICK,    4'd0,  32'd0,          1'b0, 0},
    '{OP_SERVICE, 4'd0,  32'd0,          1'b0, 1},
    '{OP_UNREG,   4'd15, 32'd0,          1'b0, 0},
    '{OP_SERVICE, 4'd0,  32'd0,          1'b0, 0}
  };

  // Send one request, honoring the stall handshake.
  task automatic send_request(in_req_t r, int want_n);
    int prior_n;
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    prior_n = pending_fires.size();
    schedule_request(r);
    if (want_n >= 0 && pending_fires.size() - prior_n != want_n) begin
      $display("%0t: result count exp %0d act %0d", $time, want_n,
               pending_fires.size() - prior_n);
      errors++;
    end
  endtask

  function automatic in_req_t rand_request(logic [31:0] near);
    in_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.event_id = 4'($urandom);
    r.periodic = 1'($urandom);
    r.timeout  = '0;
    if (pick < 35) r.operation = OP_TICK;
    else if (pick < 55) r.operation = OP_SERVICE;
    else if (pick < 88) begin
      r.operation = OP_REG;
      case ($urandom_range(0, 9))
        0:       r.timeout = '0;
        1:       r.timeout = $urandom;             // far future, all bits
        default: r.timeout = $urandom_range(1, near);
      endcase
    end else r.operation = OP_UNREG;
    return r;
  endfunction

  // Stimulus: reset, directed table, all-slot arm, then random bursts with gaps.
  initial begin
    in_req_t r;
    clock_ticks = '0; arm_seq = '0;
    for (int s = 0; s < Slots; s++) begin
      armed_q[s] = 0; repeat_q[s] = 0; interval_q[s] = '0;
      deadline_q[s] = '0; order_q[s] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      r.operation = dir_rows[i].op;
      r.event_id  = dir_rows[i].id;
      r.timeout   = dir_rows[i].tmo;
      r.periodic  = dir_rows[i].per;
      send_request(r, dir_rows[i].want_n);
    end

    // Many slots due at once: arm all 16 with small timeouts.
    for (int s = 0; s < Slots; s++) begin
      r.operation = OP_REG; r.event_id = 4'(s);
      r.timeout = $urandom_range(1, 2); r.periodic = 1'($urandom);
      send_request(r, 1);
    end

    for (int n = 0; n < 250; ) begin
      int burst;
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++, n++)
        send_request(rand_request(n < 120 ? 32'd4 : 32'd12), -1);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stall pattern: phases of free flow and phases of random stall.
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk_i);
        out_stall_i <= (mode == 0) ? 1'b0 :
                       (mode == 1) ? ($urandom_range(0, 3) == 0) :
                                     ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    out_req_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_fires.size() == 0) begin
        $display("%0t: unexpected result act %p", $time, out_req_o);
        errors++;
      end else begin
        want = pending_fires.pop_front();
        if (out_req_o.kind !== want.kind)
          $display("%0t: kind exp %0d act %0d", $time, want.kind, out_req_o.kind);
        if (out_req_o.fired_id !== want.fired_id)
          $display("%0t: fired_id exp %0d act %0d", $time, want.fired_id,
                   out_req_o.fired_id);
        if (out_req_o.status !== want.status)
          $display("%0t: status exp %0d act %0d", $time, want.status,
                   out_req_o.status);
        if (out_req_o.last !== want.last)
          $display("%0t: last exp %0d act %0d", $time, want.last, out_req_o.last);
        if (out_req_o !== want) errors++;
      end
    end
  end

  // Drain and verdict.
  initial begin
    wait (stim_done);
    while (pending_fires.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0) $display("PASS timer_event_queue_top");
    else $display("FAIL timer_event_queue_top");
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("FAIL timer_event_queue_top");
    $finish;
  end
endmodule
